// ===== rtl/tekd_pkg.sv =====
package tekd_pkg;

   // input item kinds
   localparam logic [1:0] MODE_CHAR = 2'd0;
   localparam logic [1:0] MODE_EOF  = 2'd1;
   localparam logic [1:0] MODE_POLL = 2'd2;

   // decoder phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_ESC    = 3'd1;
   localparam logic [2:0] PH_CSI    = 3'd2;
   localparam logic [2:0] PH_SS3    = 3'd3;
   localparam logic [2:0] PH_DIGIT  = 3'd4;
   localparam logic [2:0] PH_FOURTH = 3'd5;
   localparam logic [2:0] PH_FINAL  = 3'd6;

   // key codes
   localparam logic [4:0] KEY_CHAR   = 5'd0;
   localparam logic [4:0] KEY_ESC    = 5'd1;
   localparam logic [4:0] KEY_NONE   = 5'd2;
   localparam logic [4:0] KEY_UP     = 5'd3;
   localparam logic [4:0] KEY_DOWN   = 5'd4;
   localparam logic [4:0] KEY_RIGHT  = 5'd5;
   localparam logic [4:0] KEY_LEFT   = 5'd6;
   localparam logic [4:0] KEY_HOME   = 5'd7;
   localparam logic [4:0] KEY_END    = 5'd8;
   localparam logic [4:0] KEY_DEL    = 5'd9;
   localparam logic [4:0] KEY_PGUP   = 5'd10;
   localparam logic [4:0] KEY_PGDN   = 5'd11;
   localparam logic [4:0] KEY_CRIGHT = 5'd12;
   localparam logic [4:0] KEY_CLEFT  = 5'd13;
   localparam logic [4:0] KEY_ALT    = 5'd14;
   localparam logic [4:0] KEY_F1     = 5'd15;
   localparam logic [4:0] KEY_F2     = 5'd16;
   localparam logic [4:0] KEY_F3     = 5'd17;
   localparam logic [4:0] KEY_F4     = 5'd18;
   localparam logic [4:0] KEY_F5     = 5'd19;
   localparam logic [4:0] KEY_F6     = 5'd20;
   localparam logic [4:0] KEY_F7     = 5'd21;
   localparam logic [4:0] KEY_F8     = 5'd22;
   localparam logic [4:0] KEY_F9     = 5'd23;
   localparam logic [4:0] KEY_F10    = 5'd24;
   localparam logic [4:0] KEY_F11    = 5'd25;
   localparam logic [4:0] KEY_F12    = 5'd26;

   // ascii characters of interest
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_SS3   = 8'h4F;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_2     = 8'h32;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_4     = 8'h34;
   localparam logic [7:0] CH_5     = 8'h35;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_8     = 8'h38;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_H     = 8'h48;

   typedef struct packed {
      logic       emit;
      logic [4:0] key_code;
      logic       alt_is_delete;
      logic       pass_char;
   } step_ctl_type;

endpackage

// ===== rtl/tekd_req_if.sv =====
interface tekd_req_if #(
   parameter int CHAR_WIDTH = 21
) ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [CHAR_WIDTH-1:0] char_in;

   modport source (output valid, output mode, output char_in, input ready);
   modport sink   (input valid, input mode, input char_in, output ready);
endinterface

// ===== rtl/tekd_rsp_if.sv =====
interface tekd_rsp_if #(
   parameter int CHAR_WIDTH = 21
) ();
   logic                  valid;
   logic                  ready;
   logic [4:0]            key_code;
   logic [CHAR_WIDTH-1:0] char_value;
   logic                  alt_is_delete;

   modport source (output valid, output key_code, output char_value, output alt_is_delete,
                   input ready);
   modport sink   (input valid, input key_code, input char_value, input alt_is_delete,
                   output ready);
endinterface

// ===== rtl/terminal_escape_key_decoder_core.sv =====
// Escape-sequence key decoder: takes one terminal character (or an end-of-input or poll
// transaction) per cycle while req_if.ready is high and returns at most one key event per
// transaction, in order. A transaction is held in the input register, where the decode
// logic and the sequence state work on it, and its result is then registered in the
// output register, or in the skid stage behind it when that is full. The sustained rate is
// one transaction per cycle while the consumer keeps up. The rate is set by the sequence
// state, which is updated once per transaction. The output side holds up to two results,
// so a stalled consumer only stops req_if.ready once both are full and the input register
// holds a transaction that gives a key event.
module terminal_escape_key_decoder_core #(
   parameter int CHAR_WIDTH = 21
) (
   input logic         clock,
   input logic         reset,
   tekd_req_if.sink    req_if,
   tekd_rsp_if.source  rsp_if
);
   import tekd_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            mode_ff, mode_in;
   logic [CHAR_WIDTH-1:0] char_ff, char_in;
   logic [2:0]            phase_ff, phase_in;
   logic [3:0]            first_ff, first_in;
   logic [7:0]            second_ff, second_in;
   logic                  third_ff, third_in;
   step_ctl_type          ctl;
   logic                  out_ready;
   logic                  advance;
   logic                  accept;

   tekd_step #(
      .CHAR_WIDTH (CHAR_WIDTH)
   ) u_step (
      .phase       (phase_ff),
      .first_digit (first_ff),
      .second_code (second_ff),
      .third_five  (third_ff),
      .mode        (mode_ff),
      .char_in     (char_ff),
      .ctl         (ctl),
      .phase_in    (phase_in),
      .first_in    (first_in),
      .second_in   (second_in),
      .third_in    (third_in)
   );

   tekd_out_reg #(
      .CHAR_WIDTH (CHAR_WIDTH)
   ) u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (advance && ctl.emit),
      .push_ctl   (ctl),
      .push_char  (char_ff),
      .push_ready (out_ready),
      .rsp_if     (rsp_if)
   );

   always_comb begin
      advance      = in_valid_ff && (!ctl.emit || out_ready);
      req_if.ready = !in_valid_ff || advance;
      accept       = req_if.valid && req_if.ready;

      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      mode_in     = accept ? req_if.mode : mode_ff;
      char_in     = accept ? req_if.char_in : char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         first_ff    <= '0;
         second_ff   <= '0;
         third_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff  <= phase_in;
            first_ff  <= first_in;
            second_ff <= second_in;
            third_ff  <= third_in;
         end
      end
      mode_ff <= mode_in;
      char_ff <= char_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (advance && mode_ff == MODE_EOF) |=> phase_ff == PH_IDLE)
      else $error("end of input left a sequence open");

   assert property (@(posedge clock) disable iff (reset)
      (advance && ctl.emit) |=> phase_ff == PH_IDLE)
      else $error("sequence still open after a key event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.key_code <= KEY_F12)
      else $error("key code out of range");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(char_ff) && $stable(mode_ff)))
      else $error("held transaction lost from the input register");

endmodule

// ===== rtl/tekd_step.sv =====
module tekd_step #(
   parameter int CHAR_WIDTH = 21
) (
   input  logic [2:0]            phase,
   input  logic [3:0]            first_digit,
   input  logic [7:0]            second_code,
   input  logic                  third_five,
   input  logic [1:0]            mode,
   input  logic [CHAR_WIDTH-1:0] char_in,
   output tekd_pkg::step_ctl_type ctl,
   output logic [2:0]            phase_in,
   output logic [3:0]            first_in,
   output logic [7:0]            second_in,
   output logic                  third_in
);
   import tekd_pkg::*;

   logic [7:0] c_code;
   logic       idle;
   logic       short_hit;
   logic [4:0] short_key;

   always_comb begin
      // anything wider than eight bits folds to nul, which matches none of the codes
      c_code = ((char_in >> 8) == '0) ? char_in[7:0] : 8'h00;
      idle   = !(phase inside {[PH_ESC:PH_FINAL]});

      short_hit = 1'b1;
      case (first_digit)
         CH_1[3:0], CH_7[3:0]: short_key = KEY_HOME;
         CH_3[3:0]:            short_key = KEY_DEL;
         CH_4[3:0], CH_8[3:0]: short_key = KEY_END;
         CH_5[3:0]:            short_key = KEY_PGUP;
         CH_6[3:0]:            short_key = KEY_PGDN;
         default: begin
            short_key = KEY_ESC;
            short_hit = 1'b0;
         end
      endcase

      ctl           = '0;
      ctl.key_code  = KEY_ESC;
      phase_in      = phase;
      first_in      = first_digit;
      second_in     = second_code;
      third_in      = third_five;

      if (mode == MODE_EOF) begin
         ctl.emit     = 1'b1;
         ctl.key_code = idle ? KEY_NONE : KEY_ESC;
      end else if (mode != MODE_CHAR) begin
         // poll inside a sequence leaves it open
         if (idle) begin
            ctl.emit     = 1'b1;
            ctl.key_code = KEY_NONE;
         end
      end else begin
         case (phase)
            PH_ESC: begin
               if (c_code == CH_LBR) begin
                  phase_in = PH_CSI;
               end else if (c_code == CH_SS3) begin
                  phase_in = PH_SS3;
               end else begin
                  ctl.emit      = 1'b1;
                  ctl.key_code  = KEY_ALT;
                  ctl.pass_char = 1'b1;
               end
            end
            PH_CSI: begin
               if (c_code inside {[CH_0:CH_9]}) begin
                  first_in = c_code[3:0];
                  phase_in = PH_DIGIT;
               end else begin
                  ctl.emit = 1'b1;
                  case (c_code)
                     CH_A:    ctl.key_code = KEY_UP;
                     CH_B:    ctl.key_code = KEY_DOWN;
                     CH_C:    ctl.key_code = KEY_RIGHT;
                     CH_D:    ctl.key_code = KEY_LEFT;
                     CH_H:    ctl.key_code = KEY_HOME;
                     CH_F:    ctl.key_code = KEY_END;
                     default: ctl.key_code = KEY_ESC;
                  endcase
               end
            end
            PH_SS3: begin
               ctl.emit = 1'b1;
               case (c_code)
                  CH_H:    ctl.key_code = KEY_HOME;
                  CH_F:    ctl.key_code = KEY_END;
                  default: ctl.key_code = KEY_ESC;
               endcase
            end
            PH_DIGIT: begin
               if (c_code == CH_TILDE && short_hit) begin
                  ctl.emit     = 1'b1;
                  ctl.key_code = short_key;
               end else begin
                  second_in = c_code;
                  phase_in  = PH_FOURTH;
               end
            end
            PH_FOURTH: begin
               third_in = (c_code == CH_5);
               ctl.emit = 1'b1;
               if (first_digit == CH_1[3:0]) begin
                  if (second_code == CH_SEMI) begin
                     if (c_code == CH_5 || c_code == CH_3) begin
                        ctl.emit = 1'b0;
                        phase_in = PH_FINAL;
                     end
                  end else if (c_code == CH_TILDE) begin
                     case (second_code)
                        CH_1:    ctl.key_code = KEY_F1;
                        CH_2:    ctl.key_code = KEY_F2;
                        CH_3:    ctl.key_code = KEY_F3;
                        CH_4:    ctl.key_code = KEY_F4;
                        CH_5:    ctl.key_code = KEY_F5;
                        CH_7:    ctl.key_code = KEY_F6;
                        CH_8:    ctl.key_code = KEY_F7;
                        CH_9:    ctl.key_code = KEY_F8;
                        default: ctl.key_code = KEY_ESC;
                     endcase
                  end
               end else if (first_digit == CH_2[3:0]) begin
                  if (c_code == CH_TILDE) begin
                     case (second_code)
                        CH_0:    ctl.key_code = KEY_F9;
                        CH_1:    ctl.key_code = KEY_F10;
                        CH_3:    ctl.key_code = KEY_F11;
                        CH_4:    ctl.key_code = KEY_F12;
                        default: ctl.key_code = KEY_ESC;
                     endcase
                  end
               end else if (first_digit == CH_3[3:0] && second_code == CH_SEMI &&
                            c_code == CH_3) begin
                  ctl.emit = 1'b0;
                  phase_in = PH_FINAL;
               end
            end
            PH_FINAL: begin
               ctl.emit = 1'b1;
               if (first_digit == CH_1[3:0] && third_five) begin
                  if (c_code == CH_C) begin
                     ctl.key_code = KEY_CRIGHT;
                  end else if (c_code == CH_D) begin
                     ctl.key_code = KEY_CLEFT;
                  end
               end else if (first_digit == CH_1[3:0]) begin
                  ctl.key_code  = KEY_ALT;
                  ctl.pass_char = 1'b1;
               end else if (first_digit == CH_3[3:0] && c_code == CH_TILDE) begin
                  ctl.key_code      = KEY_ALT;
                  ctl.alt_is_delete = 1'b1;
               end
            end
            default: begin
               // idle, also any phase code that should never occur
               if (c_code == CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  ctl.emit      = 1'b1;
                  ctl.key_code  = KEY_CHAR;
                  ctl.pass_char = 1'b1;
               end
            end
         endcase
      end

      if (ctl.emit) begin
         phase_in = PH_IDLE;
      end
   end

endmodule

// ===== rtl/tekd_out_reg.sv =====
module tekd_out_reg #(
   parameter int CHAR_WIDTH = 21
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tekd_pkg::step_ctl_type push_ctl,
   input  logic [CHAR_WIDTH-1:0]  push_char,
   output logic                   push_ready,
   tekd_rsp_if.source             rsp_if
);
   import tekd_pkg::*;

   logic                  main_valid_ff, main_valid_in;
   logic [4:0]            main_key_ff, main_key_in;
   logic [CHAR_WIDTH-1:0] main_char_ff, main_char_in;
   logic                  main_del_ff, main_del_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [4:0]            skid_key_ff, skid_key_in;
   logic [CHAR_WIDTH-1:0] skid_char_ff, skid_char_in;
   logic                  skid_del_ff, skid_del_in;
   logic [CHAR_WIDTH-1:0] new_char;
   logic                  pop;

   always_comb begin
      new_char   = push_ctl.pass_char ? push_char : '0;
      push_ready = !skid_valid_ff;
      pop        = main_valid_ff && rsp_if.ready;

      main_valid_in = main_valid_ff;
      main_key_in   = main_key_ff;
      main_char_in  = main_char_ff;
      main_del_in   = main_del_ff;
      skid_valid_in = skid_valid_ff;
      skid_key_in   = skid_key_ff;
      skid_char_in  = skid_char_ff;
      skid_del_in   = skid_del_ff;

      if (pop) begin
         if (skid_valid_ff) begin
            main_key_in   = skid_key_ff;
            main_char_in  = skid_char_ff;
            main_del_in   = skid_del_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_key_in   = push_ctl.key_code;
            main_char_in  = new_char;
            main_del_in   = push_ctl.alt_is_delete;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_key_in   = push_ctl.key_code;
            main_char_in  = new_char;
            main_del_in   = push_ctl.alt_is_delete;
         end else begin
            skid_valid_in = 1'b1;
            skid_key_in   = push_ctl.key_code;
            skid_char_in  = new_char;
            skid_del_in   = push_ctl.alt_is_delete;
         end
      end

      rsp_if.valid         = main_valid_ff;
      rsp_if.key_code      = main_key_ff;
      rsp_if.char_value    = main_char_ff;
      rsp_if.alt_is_delete = main_del_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_key_ff  <= main_key_in;
      main_char_ff <= main_char_in;
      main_del_ff  <= main_del_in;
      skid_key_ff  <= skid_key_in;
      skid_char_ff <= skid_char_in;
      skid_del_ff  <= skid_del_in;
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !skid_valid_ff)
      else $error("result pushed into a full output buffer");

   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a result while the output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      (push && main_valid_ff && !rsp_if.ready) |=> skid_valid_ff)
      else $error("stalled result was dropped instead of parked in the skid stage");

endmodule
